// ----- design/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for the hyperplane translation score
// Payload structs for both channels and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int MAX_DIM_DEF = 128;
  localparam int ELEM_W      = 16;
  localparam int ACC_W       = 40;
  localparam int SCORE_W     = 41;

  typedef struct packed {
    logic signed [ELEM_W-1:0] head_value;
    logic signed [ELEM_W-1:0] tail_value;
    logic signed [ELEM_W-1:0] normal_value;
    logic signed [ELEM_W-1:0] translation_value;
    logic                     last_elem;
  } hts_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      overflow;
  } hts_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // accept one element transaction
    logic rescale;  // rescale and clamp both dot products
    logic pass_rd;  // read one stored dimension for the second pass
    logic finish;   // emit the score and clear the triple state
  } hts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;  // second-pass pipeline still holds work
  } hts_status_t;

endpackage

// ----- design/hts_ctrl.sv -----
// ----------------------------------------------------------------------------
// hts_ctrl: sequencing controller
// Walks load, rescale, second pass and drain, and issues datapath commands.
// ----------------------------------------------------------------------------
module hts_ctrl #(
  parameter int MAX_DIM = hts_pkg::MAX_DIM_DEF,
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int CNT_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_elem,
  input  logic [CNT_W-1:0]    cnt,
  input  hts_pkg::hts_status_t status,
  output logic                busy,
  output logic [AW-1:0]       rd_addr,
  output hts_pkg::hts_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_RESCALE = 3'd2;
  localparam logic [2:0] ST_PASS    = 3'd3;
  localparam logic [2:0] ST_DRAIN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          accept;
  logic          pass_last;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pass_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt);
  assign rd_addr   = idx_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.load    = accept;
    cmd.rescale = 1'b0;
    cmd.pass_rd = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && last_elem) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_RESCALE;
      end
      ST_RESCALE: begin
        cmd.rescale = 1'b1;
        idx_nxt     = '0;
        state_nxt   = ST_PASS;
      end
      ST_PASS: begin
        cmd.pass_rd = 1'b1;
        idx_nxt     = idx_r + AW'(1);
        if (pass_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- design/hts_dp.sv -----
// ----------------------------------------------------------------------------
// hts_dp: element store, dot accumulators and second-pass pipeline
// Holds the vectors, forms saturated dot products and the L1 sum.
// ----------------------------------------------------------------------------
module hts_dp #(
  parameter int MAX_DIM = hts_pkg::MAX_DIM_DEF,
  parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int CNT_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hts_pkg::hts_cmd_t    cmd,
  input  hts_pkg::hts_in_t     in_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [CNT_W-1:0]     cnt,
  output hts_pkg::hts_status_t status,
  output logic                 out_valid,
  output hts_pkg::hts_out_t    out_data
);

  localparam int EW    = hts_pkg::ELEM_W;
  localparam int ACC_W = hts_pkg::ACC_W;
  localparam int SC_W  = hts_pkg::SCORE_W;
  localparam int SUM_W = $clog2(MAX_DIM) + 34;

  function automatic logic [ACC_W:0] acc_sat(input logic signed [ACC_W-1:0] acc,
                                             input logic signed [2*EW-1:0] p);
    logic signed [ACC_W:0] s;
    logic [ACC_W:0]        res;
    s = {acc[ACC_W-1], acc} + {{(ACC_W+1-2*EW){p[2*EW-1]}}, p};
    if (s[ACC_W] != s[ACC_W-1]) begin
      res = {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
    end else begin
      res = {1'b0, s[ACC_W-1:0]};
    end
    return res;
  endfunction

  // floor shift by 12, then clamp to the element range
  function automatic logic [EW:0] dot_q12(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-13:0] q;
    logic [EW:0]       res;
    q = acc[ACC_W-1:12];
    if ((&q[ACC_W-13:EW-1]) || !(|q[ACC_W-13:EW-1])) begin
      res = {1'b0, q[EW-1:0]};
    end else begin
      res = {1'b1, q[ACC_W-13], {(EW-1){~q[ACC_W-13]}}};
    end
    return res;
  endfunction

  logic [4*EW-1:0]          elem_mem_r [MAX_DIM];
  logic [4*EW-1:0]          rd_data_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     store;
  logic                     ovf_r, ovf_nxt;

  logic signed [2*EW-1:0]   ph_r, pt_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  hacc_r, hacc_nxt, tacc_r, tacc_nxt;
  logic [ACC_W:0]           hsum, tsum;
  logic [EW:0]              hq, tq;
  logic signed [EW-1:0]     dh_r, dt_r;
  logic signed [EW:0]       dd;

  logic                     v1_r, v2_r, v3_r;
  logic signed [EW-1:0]     hv, tv, wv, rv;
  logic signed [EW+1:0]     base_nxt, base_r;
  logic signed [2*EW:0]     prod_nxt, prod_r;
  logic signed [33:0]       diff;
  logic [33:0]              mag_nxt, mag_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SC_W-1:0]          score_mag;

  logic                     out_valid_r;
  hts_pkg::hts_out_t        out_data_r;

  assign store = cmd.load && (cnt_r < CNT_W'(MAX_DIM));
  assign cnt   = cnt_r;

  // element store: one write port for the load, one read port for the pass
  always_ff @(posedge clk) begin
    if (store) begin
      elem_mem_r[cnt_r[AW-1:0]] <= {in_data.head_value, in_data.tail_value,
                                    in_data.normal_value, in_data.translation_value};
    end
    if (cmd.pass_rd) rd_data_r <= elem_mem_r[rd_addr];
  end

  // load: register products, accumulate them in the following cycle
  assign hsum = acc_sat(hacc_r, ph_r);
  assign tsum = acc_sat(tacc_r, pt_r);
  assign hq   = dot_q12(hacc_r);
  assign tq   = dot_q12(tacc_r);
  assign dd   = {dh_r[EW-1], dh_r} - {dt_r[EW-1], dt_r};

  always_comb begin
    hacc_nxt = hacc_r;
    tacc_nxt = tacc_r;
    ovf_nxt  = ovf_r;
    if (cmd.load && !store) ovf_nxt = 1'b1;
    if (pv_r) begin
      hacc_nxt = hsum[ACC_W-1:0];
      tacc_nxt = tsum[ACC_W-1:0];
      if (hsum[ACC_W] || tsum[ACC_W]) ovf_nxt = 1'b1;
    end
    if (cmd.rescale && (hq[EW] || tq[EW])) ovf_nxt = 1'b1;
    if (cmd.finish) begin
      hacc_nxt = '0;
      tacc_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // second pass: read, multiply, absolute difference, accumulate
  assign hv       = rd_data_r[4*EW-1:3*EW];
  assign tv       = rd_data_r[3*EW-1:2*EW];
  assign wv       = rd_data_r[2*EW-1:EW];
  assign rv       = rd_data_r[EW-1:0];
  assign base_nxt = {{2{tv[EW-1]}}, tv} - {{2{hv[EW-1]}}, hv} - {{2{rv[EW-1]}}, rv};
  assign prod_nxt = dd * wv;
  assign diff     = {{4{base_r[EW+1]}}, base_r, 12'b0} + {prod_r[2*EW], prod_r};
  assign mag_nxt  = diff[33] ? (34'd0 - diff) : diff;

  assign score_mag     = SC_W'(sum_r >> 12);
  assign status.pipe_busy = v1_r || v2_r || v3_r;

  always_ff @(posedge clk) begin
    ph_r   <= in_data.normal_value * in_data.head_value;
    pt_r   <= in_data.normal_value * in_data.tail_value;
    base_r <= base_nxt;
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    if (cmd.rescale) begin
      dh_r <= hq[EW-1:0];
      dt_r <= tq[EW-1:0];
    end
    if (cmd.finish) begin
      out_data_r.score    <= SC_W'(0) - score_mag;
      out_data_r.overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pv_r        <= 1'b0;
      hacc_r      <= '0;
      tacc_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r        <= store;
      hacc_r      <= hacc_nxt;
      tacc_r      <= tacc_nxt;
      ovf_r       <= ovf_nxt;
      v1_r        <= cmd.pass_rd;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        cnt_r <= '0;
        sum_r <= '0;
      end else begin
        if (store) cnt_r <= cnt_r + CNT_W'(1);
        if (v3_r) sum_r <= sum_r + SUM_W'(mag_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/hyperplane_translation_score.sv -----
// ----------------------------------------------------------------------------
// hyperplane_translation_score: TransH-style L1 score of one triple
// Loads head, tail, normal and translation one dimension per transaction,
// then projects onto the hyperplane and returns minus the L1 distance.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive in_data and raise start; a transaction is taken at each
//   clock edge with start high and busy low. While loading, busy stays low,
//   so one dimension goes in per cycle. The transaction with last_elem set
//   ends the vector and raises busy for the second pass.
//   Output: out_valid strobes for exactly one cycle with out_data (score,
//   overflow). The receiver cannot stall; capture the result on the strobe.
//   Sequence: the strobe comes once the second pass has drained, and busy
//   drops in that same cycle. The second pass is bound by the single read
//   port of the element store, one dimension per cycle.
//   Transactions past MAX_DIM are dropped and flag overflow; saturation of
//   a dot product also flags it.
//   Reset: rst_n low clears the accumulators, count, flag and sequencer.
//   The element store holds no reset; only entries of the current vector
//   are ever read.
// ----------------------------------------------------------------------------
module hyperplane_translation_score #(
  parameter int MAX_DIM = hts_pkg::MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hts_pkg::hts_in_t  in_data,
  output logic              out_valid,
  output hts_pkg::hts_out_t out_data
);

  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  hts_pkg::hts_cmd_t    cmd;
  hts_pkg::hts_status_t status;
  logic [AW-1:0]        rd_addr;
  logic [CNT_W-1:0]     cnt;

  // sequencer: load, rescale, pass, drain
  hts_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_elem (in_data.last_elem),
    .cnt       (cnt),
    .status    (status),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .cmd       (cmd)
  );

  // storage, dot accumulators and the projection pipeline
  hts_dp #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW),
    .CNT_W   (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .rd_addr   (rd_addr),
    .cnt       (cnt),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- design/hts_checker.sv -----
// ----------------------------------------------------------------------------
// hts_checker: port-level checks for the hyperplane translation score
// Strobe shape, busy sequencing and score sign, bound to the top level.
// ----------------------------------------------------------------------------
module hts_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input hts_pkg::hts_in_t  in_data,
  input logic              out_valid,
  input hts_pkg::hts_out_t out_data
);

  // a result lasts one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // a marked last transaction starts the second pass
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_elem) |=> busy)
    else $error("busy did not rise after last element");

  // busy ends exactly when the result is shown
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

  // the score is minus a distance
  a_score_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.score) <= 0))
    else $error("positive score");

endmodule

bind hyperplane_translation_score hts_checker u_chk (.*);

// ----- bench/tb_hyperplane_translation_score.sv -----
// ----------------------------------------------------------------------------
// tb_hyperplane_translation_score: self-checking bench for the triple scorer
// Drives vectors of head/tail/normal/translation elements through the input
// channel, predicts each score and overflow flag, and checks every strobed result.
// ----------------------------------------------------------------------------
module tb_hyperplane_translation_score;

  localparam int DIM      = hts_pkg::MAX_DIM_DEF;
  localparam int IDLE_PCT = 27;
  localparam int N_ITEMS  = 1050;

  // Score tracker: mirrors the element stores and dot accumulators, queues
  // one expected result per vector and compares strobed results in order.
  class score_board;
    longint              head_mem  [DIM];
    longint              tail_mem  [DIM];
    longint              norm_mem  [DIM];
    longint              trans_mem [DIM];
    longint              head_dot;
    longint              tail_dot;
    int                  elem_cnt;
    bit                  ovf;
    hts_pkg::hts_out_t   score_q[$];
    int                  errors;

    function new();
      errors = 0;
      clear_triple();
    endfunction

    function void clear_triple();
      head_dot = 0;
      tail_dot = 0;
      elem_cnt = 0;
      ovf      = 1'b0;
    endfunction

    // Add one Q7.24 product into a 40-bit signed accumulator, clamping.
    function longint sat_acc(longint acc, longint p);
      longint s;
      s = acc + p;
      if (s > 64'sd549755813887) begin
        ovf = 1'b1;
        return 64'sd549755813887;
      end
      if (s < -64'sd549755813888) begin
        ovf = 1'b1;
        return -64'sd549755813888;
      end
      return s;
    endfunction

    // Floor-shift a dot product to Q3.12 and clamp to 16-bit signed.
    function longint dot_q12(longint acc);
      longint v;
      v = acc >>> 12;
      if (v > 32767) begin
        ovf = 1'b1;
        return 32767;
      end
      if (v < -32768) begin
        ovf = 1'b1;
        return -32768;
      end
      return v;
    endfunction

    function void note_input(hts_pkg::hts_in_t item);
      longint            h, t, w, r, dh, dt, d, sum;
      hts_pkg::hts_out_t res;
      h = $signed(item.head_value);
      t = $signed(item.tail_value);
      w = $signed(item.normal_value);
      r = $signed(item.translation_value);
      if (elem_cnt < DIM) begin
        head_mem[elem_cnt]  = h;
        tail_mem[elem_cnt]  = t;
        norm_mem[elem_cnt]  = w;
        trans_mem[elem_cnt] = r;
        head_dot = sat_acc(head_dot, w * h);
        tail_dot = sat_acc(tail_dot, w * t);
        elem_cnt++;
      end else begin
        // drop the element past the store depth and flag it
        ovf = 1'b1;
      end
      if (!item.last_elem) return;

      dh  = dot_q12(head_dot);
      dt  = dot_q12(tail_dot);
      sum = 0;
      for (int i = 0; i < elem_cnt; i++) begin
        d = tail_mem[i] * 4096 - dt * norm_mem[i] - head_mem[i] * 4096
            + dh * norm_mem[i] - trans_mem[i] * 4096;
        sum += (d < 0) ? -d : d;
      end
      res.score    = hts_pkg::SCORE_W'(-(sum >>> 12));
      res.overflow = ovf;
      score_q      = {score_q, res};
      clear_triple();
    endfunction

    function void check_result(hts_pkg::hts_out_t got);
      hts_pkg::hts_out_t want;
      if (score_q.size() == 0) begin
        $error("score: no result expected, actual %0d", got.score);
        errors++;
        return;
      end
      want = score_q.pop_front();
      if (got.score !== want.score) begin
        $error("score: expected %0d, actual %0d", want.score, got.score);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  hts_pkg::hts_in_t  in_data;
  logic              out_valid;
  hts_pkg::hts_out_t out_data;

  score_board sb;
  int         sent;
  bit         idle_off;

  hyperplane_translation_score #(.MAX_DIM(DIM)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watch both channels. All sampled values are the ones held before the
  // edge, since every input is driven with nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Hold one element transaction on the port until the block takes it.
  task automatic send_item(hts_pkg::hts_in_t item);
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      start   <= 1'b0;
      in_data <= hts_pkg::hts_in_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic hts_pkg::hts_in_t mk_item(int h, int t, int w, int r, bit last);
    hts_pkg::hts_in_t it;
    it.head_value        = hts_pkg::ELEM_W'(h);
    it.tail_value        = hts_pkg::ELEM_W'(t);
    it.normal_value      = hts_pkg::ELEM_W'(w);
    it.translation_value = hts_pkg::ELEM_W'(r);
    it.last_elem         = last;
    return it;
  endfunction

  // Pick an element: mostly full-range, with extremes, small values and
  // unit-scale normals mixed in so both saturating and clean dots occur.
  function automatic int rand_elem();
    case ($urandom_range(9))
      0:       return 32767;
      1:       return -32768;
      2:       return $urandom_range(511) - 256;
      3, 4:    return $urandom_range(8192) - 4096;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++)
      send_item(mk_item(rand_elem(), rand_elem(), rand_elem(), rand_elem(), i == len - 1));
  endtask

  initial begin
    int len, pick;
    sb       = new();
    sent     = 0;
    idle_off = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: vectors of one and two dimensions at the extremes and a zero
    // vector; the extreme ones drive both dot products into rescale saturation.
    send_item(mk_item(32767, 32767, 32767, 32767, 1'b1));
    send_item(mk_item(-32768, -32768, -32768, -32768, 1'b1));
    send_item(mk_item(0, 0, 0, 0, 1'b1));
    send_item(mk_item(32767, -32768, -32768, 32767, 1'b1));
    send_item(mk_item(-32768, 32767, 32767, -32768, 0));
    send_item(mk_item(32767, -32768, -32768, 32767, 1'b1));
    // Unit normal along one axis: clean projection, no saturation.
    send_item(mk_item(4096, -2048, 4096, 1024, 0));
    send_item(mk_item(1234, 5678, 0, -4096, 0));
    send_item(mk_item(-300, 77, 0, 12, 1'b1));
    // Full-depth vector, then one past the depth whose last element is
    // itself dropped.
    send_vector(DIM);
    send_vector(DIM + 2);

    // Random vectors: mostly short, some long, a few past the depth.
    while (sent < N_ITEMS) begin
      idle_off = (sent >= 400 && sent < 650);
      pick = $urandom_range(99);
      if (pick < 60)      len = $urandom_range(8, 1);
      else if (pick < 85) len = $urandom_range(32, 9);
      else if (pick < 95) len = $urandom_range(DIM, 33);
      else                len = $urandom_range(DIM + 6, DIM + 1);
      send_vector(len);
    end
    start <= 1'b0;

    // Drain: wait out the last second pass, then keep watching for any stray
    // strobe.
    while (sb.score_q.size() != 0) @(posedge clk);
    repeat (DIM + 16) @(posedge clk);
    if (sb.errors == 0 && sb.score_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/hts_pkg.sv
design/hts_ctrl.sv
design/hts_dp.sv
design/hyperplane_translation_score.sv
design/hts_checker.sv
bench/tb_hyperplane_translation_score.sv
